/* hw/rtl/rtc_pkg.sv */
// ----------------------------------------------------------------------------
// rtc_pkg: shared types and constants of the row to chunk locator
// Holds the field widths, command and status codes, the controller states
// and the link record that the search cells hand along the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rtc_pkg;

  localparam int MaxChunksDefault = 64;
  localparam int RowW = 31;
  localparam int ChunkW = 6;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  typedef struct packed {
    logic              hit;
    logic [ChunkW-1:0] chunk;
    logic [RowW-1:0]   offset;
  } link_t;

endpackage

`default_nettype wire

/* hw/rtl/row_to_chunk_locator.sv */
// ----------------------------------------------------------------------------
// row_to_chunk_locator: chunk row-range table with row lookup
// Appends chunk lengths into a table of row ranges and maps a global row
// number to its chunk number and the offset inside that chunk.
// ----------------------------------------------------------------------------
// Usage:
// An item is accepted at a rising edge with start high and busy low. An
// append (command 0) adds one chunk of chunk_length rows; a lookup
// (command 1) locates row_index. Each item gives one result, shown on
// status, chunk_number and row_offset for exactly one cycle while done is
// high. The receiver cannot stall; results must be taken when shown.
// An append, and a lookup of a negative or too large row, gives its result
// in the cycle after acceptance and busy stays low.
// A lookup in range sends the row down a chain of MAX_CHUNKS cells, one cell
// per cycle, each cell owning one chunk's range. Busy is high until the
// result is shown, so no new item is accepted while a lookup is in the chain.
// Reset empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module row_to_chunk_locator #(
  parameter int MAX_CHUNKS = rtc_pkg::MaxChunksDefault
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire                              command,
  input  wire  [30:0]                      chunk_length,
  input  wire  signed [31:0]               row_index,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [rtc_pkg::ChunkW-1:0]       chunk_number,
  output logic [rtc_pkg::RowW-1:0]         row_offset
);

  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  rtc_pkg::state_t          state;
  rtc_pkg::state_t          state_next;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         chunks_loaded;
  logic [rtc_pkg::RowW-1:0] total_rows;
  logic [rtc_pkg::RowW-1:0] row;
  logic                     accept;
  logic                     finish;
  logic                     out_of_range;
  logic [rtc_pkg::RowW:0]   sum;
  rtc_pkg::status_t         append_status;
  logic                     wr_en;
  logic [rtc_pkg::RowW-1:0] wr_last;
  rtc_pkg::link_t           links [MAX_CHUNKS+1];

  always_comb begin
    sum          = {1'b0, total_rows} + {1'b0, chunk_length};
    wr_last      = sum[rtc_pkg::RowW-1:0] - rtc_pkg::RowW'(1);
    out_of_range = row_index[31] || (row_index[30:0] >= total_rows);
    if (chunk_length == '0) begin
      append_status = rtc_pkg::ST_EMPTY;
    end else if (chunks_loaded >= CNT_W'(MAX_CHUNKS)) begin
      append_status = rtc_pkg::ST_FULL;
    end else if (sum[rtc_pkg::RowW]) begin
      append_status = rtc_pkg::ST_FULL;
    end else begin
      append_status = rtc_pkg::ST_OK;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rtc_pkg::S_IDLE: begin
        if (start && (command == rtc_pkg::CMD_LOOKUP) && !out_of_range) begin
          state_next = rtc_pkg::S_SEARCH;
        end
      end
      rtc_pkg::S_SEARCH: begin
        if (count == CNT_W'(MAX_CHUNKS)) begin
          state_next = rtc_pkg::S_IDLE;
        end
      end
      default: state_next = rtc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state != rtc_pkg::S_IDLE);
    accept = start && !busy;
    finish = (state == rtc_pkg::S_SEARCH) && (count == CNT_W'(MAX_CHUNKS));
    wr_en  = accept && (command == rtc_pkg::CMD_APPEND) &&
             (append_status == rtc_pkg::ST_OK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rtc_pkg::S_IDLE;
      count         <= '0;
      chunks_loaded <= '0;
      total_rows    <= '0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (accept && (command == rtc_pkg::CMD_APPEND || out_of_range)) ||
               finish;
      if (accept) begin
        count <= '0;
      end else if (state == rtc_pkg::S_SEARCH) begin
        count <= count + CNT_W'(1);
      end
      if (wr_en) begin
        chunks_loaded <= chunks_loaded + CNT_W'(1);
        total_rows    <= sum[rtc_pkg::RowW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (command == rtc_pkg::CMD_LOOKUP)) begin
      row <= row_index[30:0];
    end
    if (accept && (command == rtc_pkg::CMD_APPEND)) begin
      status       <= append_status;
      chunk_number <= '0;
      row_offset   <= '0;
    end else if (accept && out_of_range) begin
      status       <= rtc_pkg::ST_NOT_FOUND;
      chunk_number <= '0;
      row_offset   <= '0;
    end else if (finish) begin
      if (links[MAX_CHUNKS].hit) begin
        status       <= rtc_pkg::ST_OK;
        chunk_number <= links[MAX_CHUNKS].chunk;
        row_offset   <= links[MAX_CHUNKS].offset;
      end else begin
        status       <= rtc_pkg::ST_NOT_FOUND;
        chunk_number <= '0;
        row_offset   <= '0;
      end
    end
  end

  assign links[0] = '0;

  for (genvar i = 0; i < MAX_CHUNKS; i++) begin : g_cell
    rtc_cell #(
      .CELL_INDEX(i),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .wr_en        (wr_en),
      .wr_index     (chunks_loaded[IDX_W-1:0]),
      .wr_first     (total_rows),
      .wr_last      (wr_last),
      .chunks_loaded(chunks_loaded),
      .row          (row),
      .link_in      (links[i]),
      .link_out     (links[i+1])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == rtc_pkg::S_SEARCH) |-> (count <= CNT_W'(MAX_CHUNKS)))
    else $error("search counter ran past the chain length");

  a_table_bound: assert property (@(posedge clk) disable iff (rst)
    chunks_loaded <= CNT_W'(MAX_CHUNKS))
    else $error("chunk count exceeds table size");

  a_search_done: assert property (@(posedge clk) disable iff (rst)
    finish |=> (done && (state == rtc_pkg::S_IDLE)))
    else $error("finished search did not deliver its item");

  a_no_append_busy: assert property (@(posedge clk) disable iff (rst)
    (state == rtc_pkg::S_SEARCH) |-> !wr_en)
    else $error("table written during a search");

endmodule

`default_nettype wire

/* hw/rtl/rtc_cell.sv */
// ----------------------------------------------------------------------------
// rtc_cell: one chunk slot of the search chain
// Stores the first and last global row of one chunk and passes a hit record
// to its neighbor every cycle, inserting its own hit when the row falls in
// its range and no earlier cell has claimed it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_cell #(
  parameter int CELL_INDEX = 0,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        wr_en,
  input  wire  [IDX_W-1:0]           wr_index,
  input  wire  [rtc_pkg::RowW-1:0]   wr_first,
  input  wire  [rtc_pkg::RowW-1:0]   wr_last,
  input  wire  [CNT_W-1:0]           chunks_loaded,
  input  wire  [rtc_pkg::RowW-1:0]   row,
  input  rtc_pkg::link_t             link_in,
  output rtc_pkg::link_t             link_out
);

  logic [rtc_pkg::RowW-1:0] first_row;
  logic [rtc_pkg::RowW-1:0] last_row;
  logic                     in_range;
  rtc_pkg::link_t           link_next;

  always_ff @(posedge clk) begin
    if (wr_en && (wr_index == IDX_W'(CELL_INDEX))) begin
      first_row <= wr_first;
      last_row  <= wr_last;
    end
  end

  always_comb begin
    in_range = (chunks_loaded > CNT_W'(CELL_INDEX)) && (row >= first_row) &&
               (row <= last_row);
    if (link_in.hit) begin
      link_next = link_in;
    end else if (in_range) begin
      link_next.hit    = 1'b1;
      link_next.chunk  = rtc_pkg::ChunkW'(CELL_INDEX);
      link_next.offset = row - first_row;
    end else begin
      link_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out <= '0;
    end else begin
      link_out <= link_next;
    end
  end

endmodule

`default_nettype wire
